// ===== sv/sndva_pkg.sv =====
// Shared types and constants of the sound voice allocator.
`timescale 1ns / 1ps

package sndva_pkg;

	localparam int DYNAMIC_CHANNELS = 8;
	localparam int IDX_W = (DYNAMIC_CHANNELS > 1) ? $clog2(DYNAMIC_CHANNELS) : 1;
	localparam int CHAN_W = 3;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CHAN_W-1:0] chan_t;

	localparam idx_t IDX_LAST = idx_t'(DYNAMIC_CHANNELS - 1);

	// Request codes.
	localparam logic [1:0] OP_START = 2'd0;
	localparam logic [1:0] OP_STOP = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	// For a start, a sub-channel of all ones asks for any slot of the entity.
	localparam logic [3:0] SUB_ANY = 4'hF;
	localparam logic [3:0] SUB_NONE = 4'h0;

	localparam logic [31:0] LIFE_START = 32'h7FFF_FFFF;

	// Response codes.
	localparam logic [2:0] STS_STARTED = 3'd0;
	localparam logic [2:0] STS_NO_FREE = 3'd1;
	localparam logic [2:0] STS_STOPPED = 3'd2;
	localparam logic [2:0] STS_MISS = 3'd3;
	localparam logic [2:0] STS_CLEARED = 3'd4;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FIN
	} state_t;

endpackage

// ===== sv/sound_voice_allocator_unit.sv =====
// Voice allocator: channel table and a sequential scan over its entries.
//
// Channel  Signals                                           Dir  Handshake
// req      op entity sub_channel will_play sound_length now  in   req_valid / req_ready
// rsp      status channel same_owner                         out  rsp_valid / rsp_ready
// cfg      cfg_wdata (viewer entity)                         in   cfg_we, no wait
//
// A start or stop visits one table entry per cycle through a single compare unit,
// a start ending early on a same-owner match and a stop on a hit, and then commits;
// a clear goes from acceptance straight to the commit. The block takes one request
// at a time and is ready again in the cycle after the result register is loaded.
// Reset empties the table and sets the viewer entity to 1.
// A stalled response holds in the result register; the commit waits until it is taken.
`timescale 1ns / 1ps

module sound_voice_allocator_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [15:0]         cfg_wdata,
	input  logic                req_valid,
	output logic                req_ready,
	input  logic [1:0]          op,
	input  logic [15:0]         entity,
	input  logic signed [3:0]   sub_channel,
	input  logic                will_play,
	input  logic [23:0]         sound_length,
	input  logic [29:0]         now,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output logic [2:0]          status,
	output logic [2:0]          channel,
	output logic                same_owner
);

	localparam int NCH = sndva_pkg::DYNAMIC_CHANNELS;

	sndva_pkg::state_t state_q, state_d;

	logic [15:0] viewer_q;

	logic [15:0] owner_entity_q [NCH];
	logic [3:0]  owner_slot_q [NCH];
	logic [31:0] end_time_q [NCH];
	logic        playing_q [NCH];

	logic [1:0]  op_q;
	logic [15:0] ent_q;
	logic [3:0]  sub_q;
	logic        play_q;
	logic [23:0] len_q;
	logic [29:0] now_q;

	sndva_pkg::idx_t idx_q, pick_q;
	logic            found_q, same_q;
	logic [31:0]     best_q;

	logic                rsp_valid_q, same_owner_q;
	logic [2:0]          status_q;
	sndva_pkg::chan_t    channel_q;

	logic        accept, load;
	logic [15:0] cur_ent;
	logic [3:0]  cur_slot;
	logic        cur_play;
	logic [31:0] left;
	logic        is_same, guarded, closer, stop_hit, last;

	// Current entry of the scan and the shared compare unit.
	always_comb begin
		cur_ent = owner_entity_q[idx_q];
		cur_slot = owner_slot_q[idx_q];
		cur_play = playing_q[idx_q];
		left = end_time_q[idx_q] - {2'b00, now_q};
		closer = $signed(left) < $signed(best_q);
		is_same = (sub_q != sndva_pkg::SUB_NONE) && (cur_ent == ent_q) &&
			((cur_slot == sub_q) || (sub_q == sndva_pkg::SUB_ANY));
		guarded = (cur_ent == viewer_q) && (ent_q != viewer_q) && cur_play;
		stop_hit = (cur_ent == ent_q) && (cur_slot == sub_q);
		last = (idx_q == sndva_pkg::IDX_LAST);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sndva_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		req_ready = 1'b0;
		load = 1'b0;
		case (state_q)
			sndva_pkg::S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					if (op == sndva_pkg::OP_START || op == sndva_pkg::OP_STOP) begin
						state_d = sndva_pkg::S_SCAN;
					end else if (op == sndva_pkg::OP_CLEAR) begin
						state_d = sndva_pkg::S_FIN;
					end
				end
			end
			sndva_pkg::S_SCAN: begin
				if (op_q == sndva_pkg::OP_START) begin
					if (is_same || last) begin
						state_d = sndva_pkg::S_FIN;
					end
				end else if (stop_hit || last) begin
					state_d = sndva_pkg::S_FIN;
				end
			end
			sndva_pkg::S_FIN: begin
				load = !rsp_valid_q || rsp_ready;
				if (load) begin
					state_d = sndva_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = sndva_pkg::S_IDLE;
			end
		endcase
	end

	assign accept = req_valid && req_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			viewer_q <= 16'd1;
		end else if (cfg_we) begin
			viewer_q <= cfg_wdata;
		end
	end

	// Request capture and scan bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			pick_q <= '0;
			found_q <= 1'b0;
			same_q <= 1'b0;
			best_q <= sndva_pkg::LIFE_START;
			op_q <= sndva_pkg::OP_START;
		end else if (accept) begin
			idx_q <= '0;
			pick_q <= '0;
			found_q <= 1'b0;
			same_q <= 1'b0;
			best_q <= sndva_pkg::LIFE_START;
			op_q <= op;
		end else if (state_q == sndva_pkg::S_SCAN) begin
			idx_q <= sndva_pkg::idx_t'(idx_q + 1'b1);
			if (op_q == sndva_pkg::OP_START) begin
				if (is_same) begin
					pick_q <= idx_q;
					same_q <= 1'b1;
					found_q <= 1'b1;
				end else if (!guarded && closer) begin
					best_q <= left;
					pick_q <= idx_q;
					found_q <= 1'b1;
				end
			end else if (stop_hit) begin
				pick_q <= idx_q;
				found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ent_q <= entity;
			sub_q <= sub_channel;
			play_q <= will_play;
			len_q <= sound_length;
			now_q <= now;
		end
	end

	// Channel table; it is changed only when the result is committed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NCH; i++) begin
				owner_entity_q[i] <= '0;
				owner_slot_q[i] <= '0;
				end_time_q[i] <= '0;
				playing_q[i] <= 1'b0;
			end
		end else if (load) begin
			if (op_q == sndva_pkg::OP_CLEAR) begin
				for (int i = 0; i < NCH; i++) begin
					owner_entity_q[i] <= '0;
					owner_slot_q[i] <= '0;
					end_time_q[i] <= '0;
					playing_q[i] <= 1'b0;
				end
			end else if (found_q) begin
				if (op_q == sndva_pkg::OP_START) begin
					owner_entity_q[pick_q] <= ent_q;
					owner_slot_q[pick_q] <= sub_q;
					playing_q[pick_q] <= play_q;
					end_time_q[pick_q] <= play_q ? ({2'b00, now_q} + {8'd0, len_q}) : 32'd0;
				end else begin
					end_time_q[pick_q] <= '0;
					playing_q[pick_q] <= 1'b0;
				end
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
			status_q <= sndva_pkg::STS_STARTED;
			channel_q <= '0;
			same_owner_q <= 1'b0;
		end else if (load) begin
			rsp_valid_q <= 1'b1;
			channel_q <= found_q ? sndva_pkg::chan_t'(pick_q) : '0;
			same_owner_q <= 1'b0;
			if (op_q == sndva_pkg::OP_CLEAR) begin
				status_q <= sndva_pkg::STS_CLEARED;
				channel_q <= '0;
			end else if (op_q == sndva_pkg::OP_START) begin
				status_q <= found_q ? sndva_pkg::STS_STARTED : sndva_pkg::STS_NO_FREE;
				same_owner_q <= same_q;
			end else begin
				status_q <= found_q ? sndva_pkg::STS_STOPPED : sndva_pkg::STS_MISS;
			end
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign status = status_q;
	assign channel = channel_q;
	assign same_owner = same_owner_q;

endmodule

// ===== sv/sndva_checker.sv =====
// Port checker for the sound voice allocator and its bind to the top level.
`timescale 1ns / 1ps

module sndva_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic [1:0]  op,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [2:0]  status,
	input logic [2:0]  channel,
	input logic        same_owner
);

	// Any accepted transaction with a meaningful code occupies the block.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready && (op == sndva_pkg::OP_START ||
		op == sndva_pkg::OP_STOP || op == sndva_pkg::OP_CLEAR)) |=> !req_ready)
		else $error("ready after accepting a transaction");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(status) &&
		$stable(channel) && $stable(same_owner)))
		else $error("stalled response changed");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (status <= sndva_pkg::STS_CLEARED))
		else $error("unknown status code");

	a_same_only_start: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && status != sndva_pkg::STS_STARTED) |-> !same_owner)
		else $error("same_owner set on a result other than a start");

	a_no_channel: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && (status == sndva_pkg::STS_NO_FREE || status == sndva_pkg::STS_MISS ||
		status == sndva_pkg::STS_CLEARED)) |-> (channel == 3'd0))
		else $error("channel given with a result that has none");

endmodule

bind sound_voice_allocator_unit sndva_checker u_sndva_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req_valid),
	.req_ready  (req_ready),
	.op         (op),
	.rsp_valid  (rsp_valid),
	.rsp_ready  (rsp_ready),
	.status     (status),
	.channel    (channel),
	.same_owner (same_owner)
);
